### src/mkws_pkg.sv
// Shared types, constants and helpers for the multi-keyword word search block.
package mkws_pkg;

  // Keyword storage geometry.
  localparam int KW_SLOTS = 8;
  localparam int WORD_MAX = 16;
  localparam int SLOT_W   = $clog2(KW_SLOTS);
  localparam int POS_W    = $clog2(WORD_MAX);
  localparam int LEN_W    = $clog2(WORD_MAX + 2);
  localparam int CNT_W    = 4;

  // Character codes used by the word splitter.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // Configuration register indexes, selected by address bit 2.
  localparam logic REG_KEYWORD_COUNT = 1'b0;
  localparam logic REG_COMBINE_ANY   = 1'b1;

  // Item commands.
  typedef enum logic [1:0] {
    CMD_KW_CHAR = 2'd0,
    CMD_KW_LEN  = 2'd1,
    CMD_TEXT    = 2'd2,
    CMD_END     = 2'd3
  } command_t;

  typedef struct packed {
    command_t          command;
    logic [2:0]        keyword_slot;
    logic [3:0]        char_pos;
    logic [7:0]        data_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]  slot_index;
    logic        found;
    logic [31:0] first_line;
    logic [31:0] line_start;
    logic        combined_hit;
    logic        last;
  } rsp_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic k_clr;
    logic k_inc;
    logic cmp_en;
    logic word_done;
    logic emit_load;
    logic track_clr;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_sweep;
    logic is_end;
    logic n_zero;
    logic k_last;
    logic eot_pend;
    logic out_free;
  } ctrl_sts_t;

  // ASCII lowercase.
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

### src/multi_keyword_word_search.sv
// Keyword load and plain text items are taken straight from idle; a word end runs a keyword
// RAM read, then a compare, for each used keyword slot before the next item is accepted.
// End of text runs that compare sweep if a word is pending, then emits one result per
// used slot, one per cycle while the result side does not stall.
// Synchronous reset clears configuration, keyword lengths, counters and hit flags;
// the keyword character RAM is not cleared and must be written before use.
module multi_keyword_word_search (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             req_valid,
  output logic             req_stall,
  input  mkws_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output mkws_pkg::rsp_t   rsp
);
  import mkws_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // The register port never waits.
  assign pready = 1'b1;

  // Sequencer.
  mkws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .sts      (sts),
    .req_stall(req_stall),
    .cmd      (cmd)
  );

  // Storage, compare and result path.
  mkws_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .req      (req),
    .cmd      (cmd),
    .sts      (sts),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule

### src/mkws_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mkws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/mkws_ctrl.sv
// Controller state machine: item intake, keyword compare sweep and result emission.
module mkws_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  mkws_pkg::ctrl_sts_t sts,
  output logic                req_stall,
  output mkws_pkg::ctrl_cmd_t cmd
);
  import mkws_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (sts.need_sweep) begin
            state_next = ST_READ;
          end else if (sts.is_end && !sts.n_zero) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_READ: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (sts.k_last) begin
          state_next = sts.eot_pend ? ST_EMIT : ST_IDLE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_EMIT: begin
        if (sts.out_free && sts.k_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.take  = req_valid;
        cmd.k_clr = 1'b1;
      end
      ST_READ: begin
        cmd = '0;
      end
      ST_CMP: begin
        cmd.cmp_en    = 1'b1;
        cmd.word_done = sts.k_last;
        cmd.k_clr     = sts.k_last;
        cmd.k_inc     = !sts.k_last;
      end
      ST_EMIT: begin
        cmd.emit_load = sts.out_free;
        cmd.track_clr = sts.out_free && sts.k_last;
        cmd.k_inc     = sts.out_free && !sts.k_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### src/mkws_datapath.sv
// Datapath: configuration registers, keyword store, word buffer, counters and hit tracking.
module mkws_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  input  mkws_pkg::req_t      req,
  input  mkws_pkg::ctrl_cmd_t cmd,
  output mkws_pkg::ctrl_sts_t sts,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mkws_pkg::rsp_t      rsp
);
  import mkws_pkg::*;

  // Configuration registers.
  logic [CNT_W-1:0] keyword_count;
  logic             combine_any;

  // Keyword lengths and text tracking state.
  logic [LEN_W-1:0]  keyword_lengths [KW_SLOTS];
  logic [7:0]        word_buffer [WORD_MAX];
  logic [LEN_W-1:0]  word_length;
  logic [LEN_W-1:0]  letter_length;
  logic              word_overflow;
  logic [31:0]       line_counter;
  logic [31:0]       current_line_start;
  logic [31:0]       byte_offset;
  logic [KW_SLOTS-1:0] hit_flags;
  logic [31:0]       hit_lines [KW_SLOTS];
  logic [31:0]       hit_line_starts [KW_SLOTS];
  logic              nl_pend;
  logic              eot_pend;
  logic [SLOT_W-1:0] k;

  // Keyword character RAM outputs, one RAM per character position.
  logic [7:0] kw_q [WORD_MAX];

  logic             cfg_write;
  logic [CNT_W-1:0] used_n;
  logic [KW_SLOTS-1:0] used_mask;
  logic             verdict;
  logic [7:0]       low_byte;
  logic             is_delim;
  logic             is_nl;
  logic             is_letter;
  logic             finish_cond;
  logic             need_sweep;
  logic [31:0]      offset_inc;
  logic [31:0]      line_inc;
  logic [LEN_W-1:0] len_val;
  logic [WORD_MAX-1:0] pos_ok;
  logic             word_match;
  logic             k_last;

  // Configuration port.
  assign cfg_write = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_COMBINE_ANY) ? {31'b0, combine_any}
                                               : {{(32-CNT_W){1'b0}}, keyword_count};

  // Slots in use and the combined verdict.
  assign used_n = (keyword_count > CNT_W'(KW_SLOTS)) ? CNT_W'(KW_SLOTS) : keyword_count;
  always_comb begin
    for (int i = 0; i < KW_SLOTS; i++) begin
      used_mask[i] = (CNT_W'(i) < used_n);
    end
  end
  assign verdict = combine_any ? |(hit_flags & used_mask) : &(hit_flags | ~used_mask);

  // Text byte classification.
  assign low_byte    = to_lower(req.data_byte);
  assign is_nl       = (req.data_byte == CH_NEWLINE);
  assign is_delim    = (req.data_byte == CH_SPACE) || (req.data_byte == CH_TAB) || is_nl;
  assign is_letter   = (low_byte >= CH_LOWER_A) && (low_byte <= CH_LOWER_Z);
  assign finish_cond = (req.command == CMD_END) || ((req.command == CMD_TEXT) && is_delim);
  assign need_sweep  = finish_cond && (word_length != '0) && !word_overflow &&
                       (used_n != '0);
  assign offset_inc  = (byte_offset == '1) ? byte_offset : byte_offset + 32'd1;
  assign line_inc    = (line_counter == '1) ? line_counter : line_counter + 32'd1;
  assign len_val     = (req.data_byte > 8'(WORD_MAX)) ? LEN_W'(WORD_MAX + 1)
                                                     : req.data_byte[LEN_W-1:0];

  // Keyword character store.
  for (genvar g = 0; g < WORD_MAX; g++) begin : g_kw_ram
    mkws_ram #(
      .WIDTH(8),
      .DEPTH(KW_SLOTS)
    ) u_ram (
      .clk  (clk),
      .we   (cmd.take && (req.command == CMD_KW_CHAR) && (req.char_pos == POS_W'(g))),
      .waddr(req.keyword_slot),
      .wdata(low_byte),
      .raddr(k),
      .rdata(kw_q[g])
    );
  end

  // Word against keyword slot k.
  always_comb begin
    for (int i = 0; i < WORD_MAX; i++) begin
      pos_ok[i] = (LEN_W'(i) >= letter_length) || (word_buffer[i] == kw_q[i]);
    end
  end
  assign word_match = (keyword_lengths[k] == letter_length) && (&pos_ok);
  assign k_last     = ({1'b0, k} == (used_n - CNT_W'(1)));

  // Status to the controller.
  assign sts.need_sweep = need_sweep;
  assign sts.is_end     = (req.command == CMD_END);
  assign sts.n_zero     = (used_n == '0);
  assign sts.k_last     = k_last;
  assign sts.eot_pend   = eot_pend;
  assign sts.out_free   = !rsp_valid || !rsp_stall;

  // Control and tracking registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      keyword_count      <= '0;
      combine_any        <= 1'b0;
      for (int i = 0; i < KW_SLOTS; i++) begin
        keyword_lengths[i] <= '0;
      end
      word_length        <= '0;
      letter_length      <= '0;
      word_overflow      <= 1'b0;
      line_counter       <= '0;
      current_line_start <= '0;
      byte_offset        <= '0;
      hit_flags          <= '0;
      nl_pend            <= 1'b0;
      eot_pend           <= 1'b0;
      k                  <= '0;
      rsp_valid          <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (paddr[2] == REG_KEYWORD_COUNT) begin
          keyword_count <= pwdata[CNT_W-1:0];
        end else begin
          combine_any <= pwdata[0];
        end
      end

      // Item intake.
      if (cmd.take) begin
        unique case (req.command)
          CMD_KW_CHAR: begin
            nl_pend <= nl_pend;
          end
          CMD_KW_LEN: begin
            keyword_lengths[req.keyword_slot] <= len_val;
          end
          CMD_TEXT: begin
            byte_offset <= offset_inc;
            if (is_delim) begin
              if (need_sweep) begin
                nl_pend  <= is_nl;
                eot_pend <= 1'b0;
              end else begin
                word_length   <= '0;
                letter_length <= '0;
                word_overflow <= 1'b0;
                if (is_nl) begin
                  line_counter       <= line_inc;
                  current_line_start <= offset_inc;
                end
              end
            end else if (word_length < LEN_W'(WORD_MAX)) begin
              word_length <= word_length + LEN_W'(1);
              if (is_letter) begin
                letter_length <= word_length + LEN_W'(1);
              end
            end else begin
              word_overflow <= 1'b1;
            end
          end
          CMD_END: begin
            if (need_sweep) begin
              eot_pend <= 1'b1;
              nl_pend  <= 1'b0;
            end else begin
              word_length   <= '0;
              letter_length <= '0;
              word_overflow <= 1'b0;
              if (used_n == '0) begin
                line_counter       <= '0;
                current_line_start <= '0;
                byte_offset        <= '0;
                hit_flags          <= '0;
              end
            end
          end
          default: nl_pend <= nl_pend;
        endcase
      end

      // First hit of slot k.
      if (cmd.cmp_en && word_match && !hit_flags[k]) begin
        hit_flags[k] <= 1'b1;
      end

      // End of the compare sweep finishes the word and any pending newline.
      if (cmd.word_done) begin
        word_length   <= '0;
        letter_length <= '0;
        word_overflow <= 1'b0;
        if (nl_pend) begin
          line_counter       <= line_inc;
          current_line_start <= byte_offset;
        end
      end

      // Clear tracking after the last result.
      if (cmd.track_clr) begin
        word_length        <= '0;
        letter_length      <= '0;
        word_overflow      <= 1'b0;
        line_counter       <= '0;
        current_line_start <= '0;
        byte_offset        <= '0;
        hit_flags          <= '0;
        eot_pend           <= 1'b0;
      end

      // Slot counter.
      if (cmd.k_clr) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k + SLOT_W'(1);
      end

      // Output register handshake.
      if (cmd.emit_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take && (req.command == CMD_TEXT) && !is_delim &&
        (word_length < LEN_W'(WORD_MAX))) begin
      word_buffer[word_length[POS_W-1:0]] <= low_byte;
    end
    if (cmd.cmp_en && word_match && !hit_flags[k]) begin
      hit_lines[k]       <= line_counter;
      hit_line_starts[k] <= current_line_start;
    end
    if (cmd.emit_load) begin
      rsp.slot_index   <= 3'(k);
      rsp.found        <= hit_flags[k];
      rsp.first_line   <= hit_flags[k] ? hit_lines[k] : 32'd0;
      rsp.line_start   <= hit_flags[k] ? hit_line_starts[k] : 32'd0;
      rsp.combined_hit <= verdict;
      rsp.last         <= k_last;
    end
  end

endmodule

### tb/tb_top.sv
// Self-checking testbench for the multi-keyword word search block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mkws_pkg::*;

  localparam int WATCHDOG     = 2000;
  localparam int DRAIN        = 40;
  localparam int ITEMS_TARGET = 350;
  localparam int PHASE_ITEMS  = 117;

  localparam logic [2:0] ADDR_KW_COUNT = {REG_KEYWORD_COUNT, 2'b00};
  localparam logic [2:0] ADDR_COMBINE  = {REG_COMBINE_ANY, 2'b00};

  // Block ports.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;

  multi_keyword_word_search i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #4 clk = ~clk;

  // Idle rates in percent, changed per phase.
  int send_idle = 37;
  int rcv_idle  = 85;
  int errors = 0;
  int items_sent = 0;
  int quiet = 0;

  // Search results still to come from the block, oldest first.
  rsp_t due_reports[$];

  // Predictor state.
  logic [7:0]  kw_chars[KW_SLOTS][WORD_MAX];
  logic [4:0]  kw_lens[KW_SLOTS];
  logic [7:0]  word_buf[WORD_MAX];
  int          word_len;
  int          letter_len;
  bit          word_long;
  logic [31:0] line_no;
  logic [31:0] line_base;
  logic [31:0] byte_pos;
  bit          hit[KW_SLOTS];
  logic [31:0] hit_line[KW_SLOTS];
  logic [31:0] hit_base[KW_SLOTS];
  logic [3:0]  cfg_count;
  logic        cfg_any;

  // What the stimulus has loaded, used to build matching words.
  logic [7:0]  stim_chars[KW_SLOTS][WORD_MAX];
  bit          stim_written[KW_SLOTS][WORD_MAX];
  int          stim_len[KW_SLOTS];

  // Directed stimulus rows.
  typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_t;
  typedef struct {
    row_kind_t  kind;
    req_t       item;
    rsp_t       want;
    logic [3:0] count;
    logic       any;
  } row_t;
  row_t plan[$];

  function automatic logic [7:0] fold(logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c | CASE_DELTA;
    end
    return c;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return c >= CH_LOWER_A && c <= CH_LOWER_Z;
  endfunction

  function automatic int slots_used();
    return (cfg_count > KW_SLOTS) ? KW_SLOTS : int'(cfg_count);
  endfunction

  function automatic void clear_tracking();
    word_len = 0;
    letter_len = 0;
    word_long = 0;
    line_no = '0;
    line_base = '0;
    byte_pos = '0;
    foreach (hit[k]) begin
      hit[k] = 0;
      hit_line[k] = '0;
      hit_base[k] = '0;
    end
  endfunction

  function automatic void reset_model();
    foreach (kw_chars[k, i]) kw_chars[k][i] = '0;
    foreach (kw_lens[k]) kw_lens[k] = '0;
    foreach (word_buf[i]) word_buf[i] = '0;
    clear_tracking();
    cfg_count = '0;
    cfg_any = 1'b0;
  endfunction

  // Compare the finished word with every keyword in use and record first hits.
  function automatic void close_word();
    int n;
    bit eq;
    n = slots_used();
    if (word_len == 0 && !word_long) return;
    if (!word_long) begin
      for (int k = 0; k < n; k++) begin
        eq = (kw_lens[k] == letter_len);
        for (int i = 0; eq && i < letter_len; i++) begin
          if (word_buf[i] != fold(kw_chars[k][i])) eq = 0;
        end
        if (eq && !hit[k]) begin
          hit[k] = 1;
          hit_line[k] = line_no;
          hit_base[k] = line_base;
        end
      end
    end
    word_len = 0;
    letter_len = 0;
    word_long = 0;
  endfunction

  // Advance the predictor by one item; queue the results it causes and return their number.
  function automatic int predict_search(req_t x);
    int n;
    int hits;
    bit verdict;
    logic [7:0] ch;
    rsp_t r;
    case (x.command)
      CMD_KW_CHAR: kw_chars[x.keyword_slot][x.char_pos] = x.data_byte;
      CMD_KW_LEN: begin
        kw_lens[x.keyword_slot] = (x.data_byte > WORD_MAX) ? 5'(WORD_MAX + 1) : x.data_byte[4:0];
      end
      CMD_TEXT: begin
        if (byte_pos != '1) byte_pos++;
        ch = x.data_byte;
        if (ch == CH_SPACE || ch == CH_TAB || ch == CH_NEWLINE) begin
          close_word();
          if (ch == CH_NEWLINE) begin
            if (line_no != '1) line_no++;
            line_base = byte_pos;
          end
        end else if (word_len < WORD_MAX) begin
          ch = fold(ch);
          word_buf[word_len] = ch;
          word_len++;
          if (is_letter(ch)) letter_len = word_len;
        end else begin
          word_long = 1;
        end
      end
      default: begin
        close_word();
        n = slots_used();
        hits = 0;
        for (int k = 0; k < n; k++) if (hit[k]) hits++;
        verdict = cfg_any ? (hits > 0) : (hits == n);
        for (int k = 0; k < n; k++) begin
          r.slot_index = 3'(k);
          r.found = hit[k];
          r.first_line = hit[k] ? hit_line[k] : '0;
          r.line_start = hit[k] ? hit_base[k] : '0;
          r.combined_hit = verdict;
          r.last = (k + 1 == n);
          due_reports.push_back(r);
        end
        clear_tracking();
        return n;
      end
    endcase
    return 0;
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_report(rsp_t got);
    rsp_t want;
    if (due_reports.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %p", $time, got);
      errors++;
      return;
    end
    want = due_reports.pop_front();
    cmp_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
    cmp_field("found", 32'(want.found), 32'(got.found));
    cmp_field("first_line", want.first_line, got.first_line);
    cmp_field("line_start", want.line_start, got.line_start);
    cmp_field("combined_hit", 32'(want.combined_hit), 32'(got.combined_hit));
    cmp_field("last", 32'(want.last), 32'(got.last));
  endfunction

  // Result checking and the watchdog on cycles with no handshake.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) check_report(rsp);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < rcv_idle);
  end

  // Offer one item, wait for it to be taken, then predict what it causes.
  task automatic drive_item(input req_t x, input bit typed, input rsp_t want);
    int n;
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= x;
    do @(posedge clk); while (req_stall);
    items_sent++;
    n = predict_search(x);
    if (typed) begin
      repeat (n) void'(due_reports.pop_back());
      due_reports.push_back(want);
    end
    if (x.command == CMD_KW_CHAR) begin
      stim_chars[x.keyword_slot][x.char_pos] = x.data_byte;
      stim_written[x.keyword_slot][x.char_pos] = 1;
    end else if (x.command == CMD_KW_LEN) begin
      stim_len[x.keyword_slot] = (x.data_byte > WORD_MAX) ? WORD_MAX + 1 : x.data_byte;
    end
  endtask

  task automatic send(command_t c, logic [2:0] s, logic [3:0] p, logic [7:0] d);
    req_t x;
    x = '{command: c, keyword_slot: s, char_pos: p, data_byte: d};
    drive_item(x, 1'b0, '0);
  endtask

  task automatic send_text(logic [7:0] d);
    send(CMD_TEXT, 3'($urandom_range(7)), 4'($urandom_range(15)), d);
  endtask

  // Stop sending until every result is in and the block has gone quiet.
  task automatic settle();
    req_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // One register write: setup cycle, access cycle, then the bus returns to idle.
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_KW_COUNT) begin
      cfg_count = data[3:0];
    end else begin
      cfg_any = data[0];
    end
  endtask

  task automatic apply_settings(logic [3:0] n, logic any);
    settle();
    reg_write(ADDR_KW_COUNT, 32'(n));
    reg_write(ADDR_COMBINE, 32'(any));
  endtask

  function automatic logic [7:0] random_letter();
    logic [7:0] c;
    c = CH_LOWER_A + 8'($urandom_range(3));
    if ($urandom_range(2) == 0) c = c - CASE_DELTA;
    return c;
  endfunction

  function automatic logic [7:0] trailer();
    case ($urandom_range(3))
      0: return "!";
      1: return ".";
      2: return ",";
      default: return "9";
    endcase
  endfunction

  function automatic logic [2:0] pick_slot();
    int n;
    n = slots_used();
    return (n > 0) ? 3'($urandom_range(n - 1)) : 3'($urandom_range(7));
  endfunction

  // Set a keyword length; characters it would expose are written first if still unset.
  task automatic set_length(logic [2:0] s, logic [7:0] d);
    int n;
    n = (d > WORD_MAX) ? 0 : int'(d);
    for (int i = 0; i < n; i++) begin
      if (!stim_written[s][i]) send(CMD_KW_CHAR, s, 4'(i), 8'($urandom_range(255)));
    end
    send(CMD_KW_LEN, s, 4'($urandom_range(15)), d);
  endtask

  // Load a whole keyword: characters in order, then its length.
  task automatic load_keyword(logic [2:0] s);
    int len;
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) len = 0;
    else if (roll == 1) len = $urandom_range(WORD_MAX + 1, 255);
    else if (roll == 2) len = $urandom_range(6, WORD_MAX);
    else len = $urandom_range(1, 4);
    if (len <= WORD_MAX) begin
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(6) == 0) send(CMD_KW_CHAR, s, 4'(i), "0" + 8'($urandom_range(9)));
        else send(CMD_KW_CHAR, s, 4'(i), random_letter());
      end
    end
    set_length(s, 8'(len));
  endtask

  // One word: a loaded keyword in random case, a short random word, a long word or noise.
  task automatic emit_word();
    int roll;
    int n;
    int k;
    logic [7:0] c;
    roll = $urandom_range(19);
    n = slots_used();
    if (roll < 9 && n > 0) begin
      k = $urandom_range(n - 1);
      if (stim_len[k] > WORD_MAX) begin
        send_text(random_letter());
      end else if (stim_len[k] == 0) begin
        send_text("7");
      end else begin
        for (int i = 0; i < stim_len[k]; i++) begin
          c = stim_chars[k][i];
          if (is_letter(c) && $urandom_range(1)) c = c - CASE_DELTA;
          send_text(c);
        end
      end
      repeat ($urandom_range(2)) send_text(trailer());
    end else if (roll < 15) begin
      repeat ($urandom_range(1, 4)) send_text(random_letter());
    end else if (roll < 17) begin
      repeat ($urandom_range(WORD_MAX + 1, WORD_MAX + 4)) send_text(random_letter());
    end else begin
      repeat ($urandom_range(1, 3)) send_text(8'($urandom_range(255)));
    end
  endtask

  task automatic emit_gap();
    case ($urandom_range(9))
      0, 1: send_text(CH_TAB);
      2, 3: send_text(CH_NEWLINE);
      4: begin
        send_text(CH_SPACE);
        send_text(CH_NEWLINE);
      end
      default: send_text(CH_SPACE);
    endcase
  endtask

  // A text of a few words, with keyword edits mixed in, closed by end of text.
  task automatic run_text();
    int words;
    repeat ($urandom_range(1, 3)) load_keyword(pick_slot());
    words = $urandom_range(2, 8);
    for (int w = 0; w < words; w++) begin
      case ($urandom_range(19))
        0: load_keyword(pick_slot());
        1: send(CMD_KW_CHAR, 3'($urandom_range(7)), 4'($urandom_range(15)),
                8'($urandom_range(255)));
        2: set_length(3'($urandom_range(7)), 8'($urandom_range(255)));
        default: ;
      endcase
      emit_word();
      if (w < words - 1 || $urandom_range(1)) emit_gap();
    end
    send(CMD_END, 3'($urandom_range(7)), 4'($urandom_range(15)), 8'($urandom_range(255)));
  endtask

  function automatic row_t row_item(command_t c, logic [2:0] s, logic [3:0] p, logic [7:0] d);
    row_t r;
    r.kind = ROW_ITEM;
    r.item = '{command: c, keyword_slot: s, char_pos: p, data_byte: d};
    r.want = '0;
    r.count = '0;
    r.any = 1'b0;
    return r;
  endfunction

  function automatic row_t row_end(logic found, logic [31:0] line, logic [31:0] base,
                                   logic verdict);
    row_t r;
    r = row_item(CMD_END, 3'd0, 4'd0, 8'h00);
    r.kind = ROW_TYPED;
    r.want = '{slot_index: 3'd0, found: found, first_line: line, line_start: base,
               combined_hit: verdict, last: 1'b1};
    return r;
  endfunction

  function automatic row_t row_cfg(logic [3:0] n, logic any);
    row_t r;
    r = row_item(CMD_END, 3'd0, 4'd0, 8'h00);
    r.kind = ROW_CFG;
    r.count = n;
    r.any = any;
    return r;
  endfunction

  initial begin
    reset_model();
    plan = '{
      // No keywords in use after reset: end of text reports nothing.
      row_item(CMD_END, 3'd0, 4'd0, 8'h00),
      row_cfg(4'd1, 1'b0),
      // Keyword "Ab" in slot 0, matched case-blind.
      row_item(CMD_KW_CHAR, 3'd0, 4'd0, "A"),
      row_item(CMD_KW_CHAR, 3'd0, 4'd1, "b"),
      row_item(CMD_KW_LEN, 3'd0, 4'd0, 8'd2),
      // A newline right after a space still starts line 1 at offset 3.
      row_item(CMD_TEXT, 3'd0, 4'd0, "x"),
      row_item(CMD_TEXT, 3'd0, 4'd0, CH_SPACE),
      row_item(CMD_TEXT, 3'd0, 4'd0, CH_NEWLINE),
      row_item(CMD_TEXT, 3'd0, 4'd0, "A"),
      row_item(CMD_TEXT, 3'd0, 4'd0, "B"),
      row_item(CMD_TEXT, 3'd0, 4'd0, "!"),
      row_end(1'b1, 32'd1, 32'd3, 1'b1),
      // Tracking was cleared, so the keyword is now missing.
      row_end(1'b0, 32'd0, 32'd0, 1'b0),
      // Highest slot and position; oversized lengths never match.
      row_item(CMD_KW_CHAR, 3'd7, 4'd15, 8'hFF),
      row_item(CMD_KW_LEN, 3'd1, 4'd15, 8'hFF),
      row_item(CMD_KW_LEN, 3'd2, 4'd0, 8'd17),
      // A count above the slot number acts as all slots; empty keywords
      // match a word that holds no letters.
      row_cfg(4'd15, 1'b1),
      row_item(CMD_TEXT, 3'd7, 4'd15, 8'h00),
      row_item(CMD_TEXT, 3'd7, 4'd15, 8'hFF),
      row_item(CMD_TEXT, 3'd0, 4'd0, CH_TAB),
      row_item(CMD_TEXT, 3'd0, 4'd0, "a"),
      row_item(CMD_END, 3'd7, 4'd15, 8'hFF),
      // All slots with AND, nothing found.
      row_cfg(4'd8, 1'b0),
      row_item(CMD_TEXT, 3'd0, 4'd0, CH_NEWLINE),
      row_item(CMD_END, 3'd0, 4'd0, 8'h00)
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        apply_settings(plan[i].count, plan[i].any);
      end else begin
        drive_item(plan[i].item, plan[i].kind == ROW_TYPED, plan[i].want);
      end
    end

    // Random texts under three idling phases.
    while (items_sent < ITEMS_TARGET) begin
      if (items_sent >= 2 * PHASE_ITEMS) begin
        send_idle = 0;
        rcv_idle = 0;
      end else if (items_sent >= PHASE_ITEMS) begin
        send_idle = 85;
        rcv_idle = 37;
      end
      case ($urandom_range(9))
        0: apply_settings(4'd0, 1'($urandom_range(1)));
        1: apply_settings(4'd15, 1'($urandom_range(1)));
        2: apply_settings(4'd8, 1'($urandom_range(1)));
        default: apply_settings(4'($urandom_range(1, 8)), 1'($urandom_range(1)));
      endcase
      run_text();
    end

    settle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
